### rtl/core/tup_pkg.sv
package tup_pkg;

  // Default widths of the converted value and of the consumed count
  localparam int VALUE_WIDTH_DEF = 64;
  localparam int COUNT_WIDTH_DEF = 16;

  localparam int CH_W   = 8;
  localparam int BASE_W = 6;

  // Character codes
  localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [CH_W-1:0] CH_NINE  = 8'h39;  // '9'
  localparam logic [CH_W-1:0] CH_LC_A  = 8'h61;  // 'a'
  localparam logic [CH_W-1:0] CH_LC_Z  = 8'h7a;  // 'z'
  localparam logic [CH_W-1:0] CH_UC_A  = 8'h41;  // 'A'
  localparam logic [CH_W-1:0] CH_UC_Z  = 8'h5a;  // 'Z'
  localparam logic [CH_W-1:0] CH_LC_X  = 8'h78;  // 'x'
  localparam logic [CH_W-1:0] CH_PLUS  = 8'h2b;  // '+'
  localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CH_W-1:0] CH_CR    = 8'h0d;

  // Radix codes
  localparam logic [BASE_W-1:0] BASE_AUTO = 6'd0;
  localparam logic [BASE_W-1:0] BASE_OCT  = 6'd8;
  localparam logic [BASE_W-1:0] BASE_DEC  = 6'd10;
  localparam logic [BASE_W-1:0] BASE_HEX  = 6'd16;

  // Decoded character class, carried in the input register
  typedef struct packed {
    logic              digit_ok;  // 0-9, a-z or A-Z
    logic [BASE_W-1:0] digit;     // digit value 0..35
    logic              space;
    logic              plus;
    logic              zero;
    logic              lc_x;
  } ch_class_t;

endpackage

### rtl/core/text_to_unsigned_parser_core.sv
// Each character is held in the input register, then the parse step writes
// any result it produces into the result register.
// Throughput: one character per cycle while the result side does not stall;
// the accumulator multiply-add by the radix is combinational, so characters follow back to back.
// Reset (rst, synchronous, active high): radix register back to automatic,
// parser idle, both pipeline registers empty.
module text_to_unsigned_parser_core #(
  parameter int VALUE_WIDTH = tup_pkg::VALUE_WIDTH_DEF,
  parameter int COUNT_WIDTH = tup_pkg::COUNT_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // radix register write channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tup_pkg::BASE_W-1:0]    cfg_data,   // number_base
  // character stream
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [tup_pkg::CH_W-1:0]      s_tdata,    // ch
  input  logic                          s_tuser,    // first
  input  logic                          s_tlast,    // last
  // result stream
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [((VALUE_WIDTH + COUNT_WIDTH + 8) / 8) * 8 - 1:0]
                                        m_tdata     // value, saturated, consumed
);

  localparam int OUT_BITS = VALUE_WIDTH + 1 + COUNT_WIDTH;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_LEAD,
    PH_SIGN,
    PH_ZERO,
    PH_PFX,
    PH_DIGITS,
    PH_DONE
  } phase_t;

  // Radix register: always ready; the user must write it only while idle (the block does not enforce this)
  logic [tup_pkg::BASE_W-1:0] number_base;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      number_base <= tup_pkg::BASE_AUTO;
    end else if (cfg_valid) begin
      number_base <= cfg_data;
    end
  end

  // ---------------------------------------------------------------------
  // Input stage: decode the character and hold it with its flags
  // ---------------------------------------------------------------------
  tup_pkg::ch_class_t in_cls_d;
  tup_pkg::ch_class_t in_cls;
  logic               in_valid;
  logic               in_first;
  logic               in_last;
  logic               advance;

  tup_decode u_decode (
    .ch  (s_tdata),
    .cls (in_cls_d)
  );

  // Advance the held character whenever the result register can take a result
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_cls   <= in_cls_d;
      in_first <= s_tuser;
      in_last  <= s_tlast;
    end
  end

  // ---------------------------------------------------------------------
  // Parse step
  // ---------------------------------------------------------------------
  phase_t                     phase, phase_next;
  logic [VALUE_WIDTH-1:0]     acc, acc_next;
  logic                       ovf_seen, ovf_seen_next;
  logic [COUNT_WIDTH-1:0]     cnt, cnt_next;
  logic [tup_pkg::BASE_W-1:0] abase, abase_next;

  // Effective state: a first character restarts from a clean string
  phase_t                     ph_cur;
  logic [VALUE_WIDTH-1:0]     acc_cur;
  logic                       ovf_cur;
  logic [COUNT_WIDTH-1:0]     cnt_cur;
  logic [tup_pkg::BASE_W-1:0] abase_cur;

  logic [tup_pkg::BASE_W-1:0] base_sel;
  logic [tup_pkg::BASE_W-1:0] lead_base;
  logic                       take_ok;
  logic [VALUE_WIDTH-1:0]     mac_val;
  logic                       mac_ovf;

  logic                       emit;
  logic [VALUE_WIDTH-1:0]     e_val;
  logic                       e_sat;
  logic [COUNT_WIDTH-1:0]     e_cnt;

  always_comb begin
    if (in_first) begin
      ph_cur    = PH_LEAD;
      acc_cur   = '0;
      ovf_cur   = 1'b0;
      cnt_cur   = '0;
      abase_cur = '0;
    end else begin
      ph_cur    = phase;
      acc_cur   = acc;
      ovf_cur   = ovf_seen;
      cnt_cur   = cnt;
      abase_cur = abase;
    end
  end

  // In the leading phases the radix is fixed by this very character
  assign lead_base = (number_base == tup_pkg::BASE_AUTO) ? tup_pkg::BASE_DEC : number_base;
  assign base_sel  = (ph_cur == PH_LEAD || ph_cur == PH_SIGN) ? lead_base : abase_cur;
  assign take_ok   = in_cls.digit_ok && (base_sel != '0) && (in_cls.digit < base_sel);

  tup_accum #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_accum (
    .acc      (acc_cur),
    .base     (base_sel),
    .digit    (in_cls.digit),
    .acc_next (mac_val),
    .ovf      (mac_ovf)
  );

  always_comb begin
    phase_next    = ph_cur;
    acc_next      = acc_cur;
    ovf_seen_next = ovf_cur;
    abase_next    = abase_cur;
    cnt_next      = (cnt_cur == '1) ? cnt_cur : cnt_cur + COUNT_WIDTH'(1);
    emit          = 1'b0;
    e_val         = '0;
    e_sat         = 1'b0;
    e_cnt         = '0;

    // Drop characters that arrive outside a string
    if (ph_cur == PH_IDLE || ph_cur == PH_DONE) begin
      phase_next = ph_cur;
      cnt_next   = cnt_cur;
    end else begin
      case (ph_cur)
        PH_LEAD, PH_SIGN: begin
          if (ph_cur == PH_LEAD && in_cls.space) begin
            phase_next = PH_LEAD;
          end else if (ph_cur == PH_LEAD && in_cls.plus) begin
            phase_next = PH_SIGN;
          end else if (in_cls.zero && (number_base == tup_pkg::BASE_AUTO ||
                                       number_base == tup_pkg::BASE_HEX)) begin
            acc_next   = '0;
            abase_next = (number_base == tup_pkg::BASE_AUTO) ? tup_pkg::BASE_OCT
                                                             : tup_pkg::BASE_HEX;
            phase_next = PH_ZERO;
          end else begin
            abase_next = lead_base;
            if (take_ok) begin
              acc_next      = mac_val;
              ovf_seen_next = ovf_cur | mac_ovf;
              phase_next    = PH_DIGITS;
            end else begin
              emit = 1'b1;
            end
          end
        end
        PH_ZERO: begin
          if (in_cls.lc_x) begin
            abase_next = tup_pkg::BASE_HEX;
            phase_next = PH_PFX;
          end else if (take_ok) begin
            acc_next      = mac_val;
            ovf_seen_next = ovf_cur | mac_ovf;
            phase_next    = PH_DIGITS;
          end else begin
            emit  = 1'b1;
            e_val = acc_cur;
            e_sat = ovf_cur;
            e_cnt = cnt_cur;
          end
        end
        PH_PFX: begin
          if (take_ok) begin
            acc_next      = mac_val;
            ovf_seen_next = ovf_cur | mac_ovf;
            phase_next    = PH_DIGITS;
          end else begin
            // "0x" without a hex digit: count up to the '0' only
            emit  = 1'b1;
            e_cnt = cnt_cur - COUNT_WIDTH'(1);
          end
        end
        default: begin
          if (take_ok) begin
            acc_next      = mac_val;
            ovf_seen_next = ovf_cur | mac_ovf;
          end else begin
            emit  = 1'b1;
            e_val = acc_cur;
            e_sat = ovf_cur;
            e_cnt = cnt_cur;
          end
        end
      endcase

      // End of string closes the parse if the character did not stop it
      if (!emit && in_last) begin
        emit = 1'b1;
        case (phase_next)
          PH_LEAD, PH_SIGN: begin
            e_cnt = '0;
          end
          PH_PFX: begin
            e_cnt = cnt_next - COUNT_WIDTH'(1);
          end
          default: begin
            e_val = acc_next;
            e_sat = ovf_seen_next;
            e_cnt = cnt_next;
          end
        endcase
      end

      if (emit) begin
        phase_next = PH_DONE;
      end
    end
  end

  // Hold parser state and the result register; advance only on a step
  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_IDLE;
      acc      <= '0;
      ovf_seen <= 1'b0;
      cnt      <= '0;
      abase    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (advance) begin
        phase    <= phase_next;
        acc      <= acc_next;
        ovf_seen <= ovf_seen_next;
        cnt      <= cnt_next;
        abase    <= abase_next;
      end
      if (advance && emit) begin
        m_tvalid <= 1'b1;
        m_tdata  <= OUT_W'({e_cnt, e_sat, e_val});
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

### rtl/core/tup_decode.sv
module tup_decode (
  input  logic [tup_pkg::CH_W-1:0] ch,
  output tup_pkg::ch_class_t       cls
);

  always_comb begin
    cls = '0;
    if (ch >= tup_pkg::CH_ZERO && ch <= tup_pkg::CH_NINE) begin
      cls.digit_ok = 1'b1;
      cls.digit    = tup_pkg::BASE_W'(ch - tup_pkg::CH_ZERO);
    end else if (ch >= tup_pkg::CH_LC_A && ch <= tup_pkg::CH_LC_Z) begin
      cls.digit_ok = 1'b1;
      cls.digit    = tup_pkg::BASE_W'(ch - tup_pkg::CH_LC_A) + tup_pkg::BASE_W'(10);
    end else if (ch >= tup_pkg::CH_UC_A && ch <= tup_pkg::CH_UC_Z) begin
      cls.digit_ok = 1'b1;
      cls.digit    = tup_pkg::BASE_W'(ch - tup_pkg::CH_UC_A) + tup_pkg::BASE_W'(10);
    end
    cls.space = (ch == tup_pkg::CH_SPACE) ||
                (ch >= tup_pkg::CH_TAB && ch <= tup_pkg::CH_CR);
    cls.plus  = (ch == tup_pkg::CH_PLUS);
    cls.zero  = (ch == tup_pkg::CH_ZERO);
    cls.lc_x  = (ch == tup_pkg::CH_LC_X);
  end

endmodule

### rtl/core/tup_accum.sv
module tup_accum #(
  parameter int VALUE_WIDTH = tup_pkg::VALUE_WIDTH_DEF
) (
  input  logic [VALUE_WIDTH-1:0]    acc,
  input  logic [tup_pkg::BASE_W-1:0] base,
  input  logic [tup_pkg::BASE_W-1:0] digit,
  output logic [VALUE_WIDTH-1:0]    acc_next,
  output logic                      ovf
);

  localparam int SUM_W = VALUE_WIDTH + tup_pkg::BASE_W + 1;

  logic [SUM_W-1:0] sum;

  // acc*base + digit exceeds all ones exactly when the value overflows
  assign sum      = SUM_W'(acc) * SUM_W'(base) + SUM_W'(digit);
  assign ovf      = |sum[SUM_W-1:VALUE_WIDTH];
  assign acc_next = ovf ? '1 : sum[VALUE_WIDTH-1:0];

endmodule

### tb/text_to_unsigned_parser_core_tb.sv
`timescale 1ns / 100ps

module text_to_unsigned_parser_core_tb;

  localparam int RES_W         = 88;    // 81 bits of fields padded to whole bytes
  localparam int RANDOM_ITEMS  = 1800;
  localparam int SETTLE_CYCLES = 8;     // idle margin after the block has drained

  // Radix settings used besides the package ones
  localparam logic [tup_pkg::BASE_W-1:0] BASE_ONE   = 6'd1;
  localparam logic [tup_pkg::BASE_W-1:0] BASE_BIN   = 6'd2;
  localparam logic [tup_pkg::BASE_W-1:0] BASE_ALNUM = 6'd36;
  localparam logic [tup_pkg::BASE_W-1:0] BASE_TOP   = 6'd63;

  typedef enum logic [2:0] {
    P_IDLE, P_LEAD, P_SIGN, P_ZERO, P_PFX, P_DIGITS, P_DONE
  } parse_phase_t;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_PERIODIC, RX_SPARSE} rx_mode_t;

  typedef struct packed {
    logic [63:0] value;
    logic        sat;
    logic [15:0] consumed;
  } conv_t;

  localparam conv_t NO_RESULT = '0;

  // One directed string: characters are read from the highest used byte of txt
  // down; bit i of fmask / lmask drives first / last on character i.
  typedef struct packed {
    logic [tup_pkg::BASE_W-1:0] base;
    logic [31:0]                txt;
    logic [2:0]                 len;
    logic [3:0]                 fmask;
    logic [3:0]                 lmask;
    bit                         typed;
    conv_t                      want;
  } dir_row_t;

  localparam int DIR_ROWS = 13;

  dir_row_t dir_tab [DIR_ROWS] = '{
    // plain decimal straight after reset
    '{tup_pkg::BASE_AUTO, "42", 3'd2, 4'b0001, 4'b0010, 1'b1, '{64'd42, 1'b0, 16'd2}},
    // prefix with no hex digit after it: count stops at the zero
    '{tup_pkg::BASE_AUTO, "0xg", 3'd3, 4'b0001, 4'b0100, 1'b1, '{64'd0, 1'b0, 16'd1}},
    // leading zero selects octal
    '{tup_pkg::BASE_AUTO, "017", 3'd3, 4'b0001, 4'b0100, 1'b0, NO_RESULT},
    // whitespace and sign only, then the string ends
    '{tup_pkg::BASE_AUTO, " +", 3'd2, 4'b0001, 4'b0010, 1'b1, '{64'd0, 1'b0, 16'd0}},
    // no digit at all
    '{tup_pkg::BASE_AUTO, "z", 3'd1, 4'b0001, 4'b0001, 1'b1, '{64'd0, 1'b0, 16'd0}},
    // characters outside any string are ignored
    '{tup_pkg::BASE_AUTO, "7q", 3'd2, 4'b0000, 4'b0010, 1'b0, NO_RESULT},
    // restart in the middle of a string drops the first one
    '{tup_pkg::BASE_AUTO, "12", 3'd2, 4'b0011, 4'b0010, 1'b0, NO_RESULT},
    '{tup_pkg::BASE_HEX, "0xFf", 3'd4, 4'b0001, 4'b1000, 1'b0, NO_RESULT},
    '{BASE_ALNUM, "zZ", 3'd2, 4'b0001, 4'b0010, 1'b0, NO_RESULT},
    // radix one: only zero is a digit
    '{BASE_ONE, "001", 3'd3, 4'b0001, 4'b0100, 1'b0, NO_RESULT},
    // top character code in the widest radix setting
    '{BASE_TOP, {8'hff}, 3'd1, 4'b0001, 4'b0001, 1'b1, '{64'd0, 1'b0, 16'd0}},
    '{BASE_TOP, "Zz", 3'd2, 4'b0001, 4'b0010, 1'b0, NO_RESULT},
    // bottom character code
    '{BASE_BIN, {8'h00}, 3'd1, 4'b0001, 4'b0001, 1'b1, '{64'd0, 1'b0, 16'd0}}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [tup_pkg::BASE_W-1:0] cfg_data  = '0;  // number_base

  logic                       s_tvalid = 1'b0;
  logic                       s_tready;
  logic [tup_pkg::CH_W-1:0]   s_tdata  = '0;   // ch
  logic                       s_tuser  = 1'b0; // first
  logic                       s_tlast  = 1'b0; // last

  logic                       m_tvalid;
  logic                       m_tready = 1'b0;
  logic [RES_W-1:0]           m_tdata;  // value[63:0], saturated[64], consumed[80:65]

  // Parser state mirrored on the testbench side
  parse_phase_t               ps_phase = P_IDLE;
  logic [63:0]                ps_acc   = '0;
  logic                       ps_ovf   = 1'b0;
  logic [15:0]                ps_count = '0;
  logic [tup_pkg::BASE_W-1:0] ps_radix = '0;
  logic [tup_pkg::BASE_W-1:0] cur_base = tup_pkg::BASE_AUTO;

  conv_t    pending [$];      // conversions still owed by the block
  int       errors     = 0;
  int       items_sent = 0;
  int       burst_left = 0;
  int       rx_tick    = 0;
  rx_mode_t rx_mode    = RX_OPEN;
  conv_t    want_r;
  conv_t    seen_r;

  text_to_unsigned_parser_core dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic bit is_blank(input logic [7:0] c);
    return c == tup_pkg::CH_SPACE || (c >= tup_pkg::CH_TAB && c <= tup_pkg::CH_CR);
  endfunction

  function automatic logic [7:0] digit_of(input logic [7:0] c);
    if (c >= tup_pkg::CH_ZERO && c <= tup_pkg::CH_NINE) return c - tup_pkg::CH_ZERO;
    if (c >= tup_pkg::CH_LC_A && c <= tup_pkg::CH_LC_Z) return c - tup_pkg::CH_LC_A + 8'd10;
    if (c >= tup_pkg::CH_UC_A && c <= tup_pkg::CH_UC_Z) return c - tup_pkg::CH_UC_A + 8'd10;
    return 8'hff;
  endfunction

  // Fold one digit of the current radix into the accumulator, clamping at all
  // ones on overflow. Returns 0 when c is no digit of the radix.
  function automatic bit accept_digit(input logic [7:0] c);
    logic [7:0]  d;
    logic [63:0] b;
    logic [63:0] lim;
    logic [63:0] rest;
    d = digit_of(c);
    b = 64'(ps_radix);
    if (b == 0 || 64'(d) >= b) return 1'b0;
    lim  = 64'hffff_ffff_ffff_ffff / b;
    rest = 64'hffff_ffff_ffff_ffff % b;
    if (ps_acc > lim || (ps_acc == lim && 64'(d) > rest)) begin
      ps_acc = '1;
      ps_ovf = 1'b1;
    end else begin
      ps_acc = ps_acc * b + 64'(d);
    end
    return 1'b1;
  endfunction

  // Advance the mirrored parser by one accepted character; got marks a result.
  task automatic parse_char(input logic [7:0] c, input bit fst, input bit lst,
                            output bit got, output conv_t r);
    logic [15:0] prev;
    got = 1'b0;
    r   = '0;
    if (fst) begin
      ps_phase = P_LEAD;
      ps_acc   = '0;
      ps_ovf   = 1'b0;
      ps_count = '0;
      ps_radix = '0;
    end else if (ps_phase == P_IDLE || ps_phase == P_DONE) begin
      return;
    end
    prev = ps_count;
    if (ps_count != 16'hffff) ps_count = ps_count + 16'd1;
    case (ps_phase)
      P_LEAD, P_SIGN: begin
        if (ps_phase == P_LEAD && is_blank(c)) begin
          // skip leading whitespace
        end else if (ps_phase == P_LEAD && c == tup_pkg::CH_PLUS) begin
          ps_phase = P_SIGN;
        end else if (c == tup_pkg::CH_ZERO && (cur_base == tup_pkg::BASE_AUTO ||
                                               cur_base == tup_pkg::BASE_HEX)) begin
          ps_acc   = '0;
          ps_radix = (cur_base == tup_pkg::BASE_AUTO) ? tup_pkg::BASE_OCT
                                                      : tup_pkg::BASE_HEX;
          ps_phase = P_ZERO;
        end else begin
          ps_radix = (cur_base == tup_pkg::BASE_AUTO) ? tup_pkg::BASE_DEC : cur_base;
          if (accept_digit(c)) ps_phase = P_DIGITS;
          else got = 1'b1;
        end
      end
      P_ZERO: begin
        if (c == tup_pkg::CH_LC_X) begin
          ps_radix = tup_pkg::BASE_HEX;
          ps_phase = P_PFX;
        end else if (accept_digit(c)) begin
          ps_phase = P_DIGITS;
        end else begin
          got = 1'b1;
          r.value = ps_acc;
          r.sat = ps_ovf;
          r.consumed = prev;
        end
      end
      P_PFX: begin
        if (accept_digit(c)) begin
          ps_phase = P_DIGITS;
        end else begin
          got = 1'b1;
          r.consumed = prev - 16'd1;
        end
      end
      default: begin
        if (!accept_digit(c)) begin
          got = 1'b1;
          r.value = ps_acc;
          r.sat = ps_ovf;
          r.consumed = prev;
        end
      end
    endcase
    if (!got && lst) begin
      got = 1'b1;
      if (ps_phase == P_PFX) begin
        r.consumed = ps_count - 16'd1;
      end else if (ps_phase != P_LEAD && ps_phase != P_SIGN) begin
        r.value = ps_acc;
        r.sat = ps_ovf;
        r.consumed = ps_count;
      end
    end
    if (got) ps_phase = P_DONE;
  endtask

  // Offer one character, idling between bursts, and record the owed result
  // once the transfer happens. A typed result overrides the predicted one.
  task automatic send_char(input logic [7:0] c, input bit fst, input bit lst,
                           input bit typed = 1'b0, input conv_t tr = '0);
    bit    got;
    conv_t r;
    int    gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    s_tuser  <= fst;
    s_tlast  <= lst;
    do @(posedge clk); while (!s_tready);
    burst_left = burst_left - 1;
    items_sent = items_sent + 1;
    parse_char(c, fst, lst, got, r);
    if (got) pending.push_back(typed ? tr : r);
  endtask

  task automatic stop_stream();
    s_tvalid <= 1'b0;
    burst_left = 0;
  endtask

  // Change the radix only once the block has drained.
  task automatic set_base(input logic [tup_pkg::BASE_W-1:0] b);
    stop_stream();
    while (pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= b;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_base = b;
  endtask

  function automatic int max_digits(input int radix);
    logic [63:0] v;
    int          n;
    v = '1;
    n = 0;
    while (v != 0) begin
      v = v / 64'(radix);
      n++;
    end
    return n;
  endfunction

  // Well-formed number with random content: blanks, sign, prefix, digits and
  // one of several endings, sometimes followed by stray characters.
  task automatic gen_string();
    logic [7:0] s [$];
    int         lastpos;
    int         radix;
    int         n;
    int         d;
    int         r;
    bit         boundary;
    lastpos = -1;
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        r = $urandom_range(0, 5);
        s.push_back((r == 5) ? tup_pkg::CH_SPACE : 8'(tup_pkg::CH_TAB + r));
      end
    end
    if ($urandom_range(0, 3) == 0) s.push_back(tup_pkg::CH_PLUS);
    radix = (cur_base > BASE_ALNUM) ? 36 : int'(cur_base);
    if (cur_base == tup_pkg::BASE_AUTO) begin
      r = $urandom_range(0, 2);
      if (r == 0) begin
        s.push_back(tup_pkg::CH_ZERO);
        s.push_back(tup_pkg::CH_LC_X);
        radix = 16;
      end else if (r == 1) begin
        s.push_back(tup_pkg::CH_ZERO);
        radix = 8;
      end else begin
        radix = 10;
      end
    end else if (cur_base == tup_pkg::BASE_HEX && $urandom_range(0, 1) == 1) begin
      s.push_back(tup_pkg::CH_ZERO);
      s.push_back(tup_pkg::CH_LC_X);
    end
    // Mostly short numbers; some long ones and some right at the clamp edge
    r = $urandom_range(0, 19);
    boundary = (r == 1 || r == 2) && radix > 1;
    if (r == 0) n = 0;
    else if (boundary) n = max_digits(radix) - 1 + $urandom_range(0, 2);
    else if (r == 3) n = $urandom_range(10, 70);
    else n = $urandom_range(1, 6);
    for (int i = 0; i < n; i++) begin
      d = (boundary || $urandom_range(0, 1) == 1) ? radix - 1 : $urandom_range(0, radix - 1);
      if (d < 10) s.push_back(8'(tup_pkg::CH_ZERO + d));
      else s.push_back(8'((($urandom_range(0, 1) == 1) ? tup_pkg::CH_UC_A
                                                        : tup_pkg::CH_LC_A) + d - 10));
    end
    if (s.size() == 0) s.push_back(tup_pkg::CH_SPACE);
    r = $urandom_range(0, 3);
    if (r == 0) begin
      lastpos = s.size() - 1;
    end else if (r < 3) begin
      s.push_back(8'($urandom_range(0, 255)));
      if (r == 1) lastpos = s.size() - 1;
    end
    for (int i = 0; i < s.size(); i++) send_char(s[i], i == 0, i == lastpos);
    if (r == 1 || r == 2) begin
      repeat ($urandom_range(0, 2))
        send_char(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic gen_noise();
    repeat ($urandom_range(1, 6))
      send_char(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0,
                $urandom_range(0, 3) == 0);
  endtask

  // Result side: check every transfer against the oldest owed conversion, and
  // stall on a pattern re-drawn at random among open, coin-flip, periodic and sparse modes.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        seen_r.value    = m_tdata[63:0];
        seen_r.sat      = m_tdata[64];
        seen_r.consumed = m_tdata[80:65];
        if (pending.size() == 0) begin
          $display("%0t: result with none owed: value=%h sat=%0d consumed=%0d",
                   $time, seen_r.value, seen_r.sat, seen_r.consumed);
          errors++;
        end else begin
          want_r = pending.pop_front();
          if (seen_r.value !== want_r.value) begin
            $display("%0t: value mismatch: expected %h, actual %h",
                     $time, want_r.value, seen_r.value);
            errors++;
          end
          if (seen_r.sat !== want_r.sat) begin
            $display("%0t: saturated mismatch: expected %0d, actual %0d",
                     $time, want_r.sat, seen_r.sat);
            errors++;
          end
          if (seen_r.consumed !== want_r.consumed) begin
            $display("%0t: consumed mismatch: expected %0d, actual %0d",
                     $time, want_r.consumed, seen_r.consumed);
            errors++;
          end
        end
      end
      rx_tick++;
      if (rx_tick % 200 == 0) rx_mode = rx_mode_t'($urandom_range(0, 3));
      case (rx_mode)
        RX_OPEN:     m_tready <= 1'b1;
        RX_COIN:     m_tready <= 1'($urandom_range(0, 1));
        RX_PERIODIC: m_tready <= (rx_tick % 5) != 0;
        default:     m_tready <= (rx_tick % 16) == 0;
      endcase
    end
  end

  initial begin
    int                         rand_start;
    int                         r;
    logic [tup_pkg::BASE_W-1:0] nb;
    dir_row_t                   row;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed strings
    for (int k = 0; k < DIR_ROWS; k++) begin
      row = dir_tab[k];
      if (row.base != cur_base) set_base(row.base);
      for (int i = 0; i < int'(row.len); i++)
        send_char(row.txt[8*(int'(row.len)-1-i) +: 8], row.fmask[i], row.lmask[i],
                  row.typed, row.want);
    end

    // Random phases, each under its own radix
    rand_start = items_sent;
    while (items_sent - rand_start < RANDOM_ITEMS) begin
      r = $urandom_range(0, 9);
      case (r)
        0, 1:    nb = tup_pkg::BASE_AUTO;
        2:       nb = tup_pkg::BASE_HEX;
        3:       nb = tup_pkg::BASE_DEC;
        4:       nb = BASE_BIN;
        5:       nb = tup_pkg::BASE_OCT;
        6:       nb = BASE_ALNUM;
        7:       nb = BASE_ONE;
        8:       nb = BASE_TOP;
        default: nb = tup_pkg::BASE_W'($urandom_range(1, 63));
      endcase
      // Close any open string so the radix never changes under it
      if (ps_phase != P_IDLE && ps_phase != P_DONE)
        send_char(tup_pkg::CH_SPACE, 1'b0, 1'b1);
      set_base(nb);
      repeat ($urandom_range(10, 25)) begin
        if ($urandom_range(0, 6) == 0) gen_noise();
        else gen_string();
      end
    end

    stop_stream();
    while (pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog against a hung handshake
  initial begin
    #100_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
